>>> hw/rtl/oale_pkg.sv
package oale_pkg;

    localparam int MODE_W   = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 4;
    localparam int FILL_W   = 5;
    localparam int MATCH_W  = 5;

    // search reports at most this many matches
    localparam int RESULT_LIMIT = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 3'd0,
        MODE_POP    = 3'd1,
        MODE_INSERT = 3'd2,
        MODE_DELETE = 3'd3,
        MODE_READ   = 3'd4,
        MODE_SEARCH = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SHIFT_UP,
        S_PLACE,
        S_DEL_GRAB,
        S_SHIFT_DN,
        S_SEARCH,
        S_FLUSH
    } t_state;

    typedef struct packed {
        t_status                   status;
        logic signed [DATA_W-1:0]  data;
        logic [POS_W-1:0]          position;
        logic [FILL_W-1:0]         fill_count;
        logic                      last;
    } t_result;

endpackage

>>> hw/rtl/oale_mem.sv
module oale_mem
    import oale_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic signed [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]            i_raddr,
    output logic signed [DATA_W-1:0] o_rdata
);

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/oale_seq.sv
module oale_seq
    import oale_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int AW       = 4,
    parameter int CW       = 5
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [MODE_W-1:0]        i_mode,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [POS_W-1:0]         i_index,
    output logic                     o_busy,
    output logic                     o_mem_we,
    output logic [AW-1:0]            o_mem_waddr,
    output logic signed [DATA_W-1:0] o_mem_wdata,
    output logic [AW-1:0]            o_mem_raddr,
    input  logic signed [DATA_W-1:0] i_mem_rdata,
    output logic                     o_res_valid,
    output t_result                  o_res
);

    localparam int CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_ptr, n_ptr;
    logic [CW-1:0]            r_pend_pos, n_pend_pos;
    logic                     r_pend_valid, n_pend_valid;
    logic [MATCH_W-1:0]       r_nmatch, n_nmatch;
    logic [POS_W-1:0]         r_idx, n_idx;
    logic signed [DATA_W-1:0] r_val, n_val;
    logic signed [DATA_W-1:0] r_word, n_word;

    logic                     accept;
    logic                     full;
    logic                     empty;
    logic                     idx_gt_cnt;
    logic                     idx_ge_cnt;
    logic                     match;
    logic                     scan_end;
    logic                     limit_hit;
    logic                     up_done;
    logic                     dn_more;
    logic [FILL_W-1:0]        fc_cur, fc_inc, fc_dec;

    assign o_busy     = (r_state != S_IDLE);
    assign accept     = i_start && !o_busy;
    assign full       = (r_count >= CW'(CAPACITY));
    assign empty      = (r_count == '0);
    assign idx_gt_cnt = (CMP_W'(i_index) > CMP_W'(r_count));
    assign idx_ge_cnt = (CMP_W'(i_index) >= CMP_W'(r_count));
    assign match      = (i_mem_rdata == r_val);
    assign scan_end   = (CW'(r_ptr + 1'b1) == r_count);
    assign limit_hit  = match && (r_nmatch == MATCH_W'(RESULT_LIMIT - 1));
    assign up_done    = (CMP_W'(r_ptr) == CMP_W'(r_idx) + CMP_W'(1));
    assign dn_more    = (CW'(r_ptr + 1'b1) < r_count);
    assign fc_cur     = FILL_W'(r_count);
    assign fc_inc     = FILL_W'(r_count + 1'b1);
    assign fc_dec     = FILL_W'(r_count - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_pend_pos   <= n_pend_pos;
        r_pend_valid <= n_pend_valid;
        r_nmatch     <= n_nmatch;
        r_idx        <= n_idx;
        r_val        <= n_val;
        r_word       <= n_word;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_mode)
                        MODE_POP: begin
                            if (!empty) n_state = S_READ;
                        end
                        MODE_INSERT: begin
                            if (!full && !idx_ge_cnt) n_state = S_SHIFT_UP;
                        end
                        MODE_DELETE: begin
                            if (!empty && !idx_ge_cnt) n_state = S_DEL_GRAB;
                        end
                        MODE_READ: begin
                            if (!empty && !idx_ge_cnt) n_state = S_READ;
                        end
                        MODE_SEARCH: begin
                            if (!empty) n_state = S_SEARCH;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_READ:     n_state = S_IDLE;
            S_SHIFT_UP: begin
                if (up_done) n_state = S_PLACE;
            end
            S_PLACE:    n_state = S_IDLE;
            S_DEL_GRAB: n_state = S_SHIFT_DN;
            S_SHIFT_DN: begin
                if (!dn_more) n_state = S_IDLE;
            end
            S_SEARCH: begin
                if (limit_hit || scan_end) n_state = S_FLUSH;
            end
            S_FLUSH:    n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_pend_pos   = r_pend_pos;
        n_pend_valid = r_pend_valid;
        n_nmatch     = r_nmatch;
        n_idx        = r_idx;
        n_val        = r_val;
        n_word       = r_word;
        o_mem_we     = 1'b0;
        o_mem_waddr  = AW'(r_ptr);
        o_mem_wdata  = i_mem_rdata;
        o_mem_raddr  = '0;
        o_res_valid  = 1'b0;
        o_res        = '{status: ST_OK, data: r_val, position: r_idx,
                         fill_count: fc_cur, last: 1'b1};
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_val = i_value;
                    n_idx = i_index;
                    unique case (i_mode)
                        MODE_APPEND: begin
                            o_res_valid = 1'b1;
                            if (full) begin
                                o_res = '{ST_FULL, i_value, '0, fc_cur, 1'b1};
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = AW'(r_count);
                                o_mem_wdata = i_value;
                                n_count     = CW'(r_count + 1'b1);
                                o_res = '{ST_OK, i_value, POS_W'(r_count), fc_inc, 1'b1};
                            end
                        end
                        MODE_POP: begin
                            if (empty) begin
                                o_res_valid = 1'b1;
                                o_res = '{ST_EMPTY, '0, '0, fc_cur, 1'b1};
                            end else begin
                                n_count     = CW'(r_count - 1'b1);
                                o_mem_raddr = AW'(r_count - 1'b1);
                                n_idx       = POS_W'(r_count - 1'b1);
                            end
                        end
                        MODE_INSERT: begin
                            if (full) begin
                                o_res_valid = 1'b1;
                                o_res = '{ST_FULL, i_value, i_index, fc_cur, 1'b1};
                            end else if (idx_gt_cnt) begin
                                o_res_valid = 1'b1;
                                o_res = '{ST_RANGE, i_value, i_index, fc_cur, 1'b1};
                            end else if (!idx_ge_cnt) begin
                                n_ptr       = r_count;
                                o_mem_raddr = AW'(r_count - 1'b1);
                            end else begin
                                // index equal to the count: plain append
                                o_res_valid = 1'b1;
                                o_mem_we    = 1'b1;
                                o_mem_waddr = AW'(r_count);
                                o_mem_wdata = i_value;
                                n_count     = CW'(r_count + 1'b1);
                                o_res = '{ST_OK, i_value, i_index, fc_inc, 1'b1};
                            end
                        end
                        MODE_DELETE, MODE_READ: begin
                            if (empty) begin
                                o_res_valid = 1'b1;
                                o_res = '{ST_EMPTY, '0, i_index, fc_cur, 1'b1};
                            end else if (idx_ge_cnt) begin
                                o_res_valid = 1'b1;
                                o_res = '{ST_RANGE, '0, i_index, fc_cur, 1'b1};
                            end else begin
                                o_mem_raddr = AW'(i_index);
                                n_ptr       = CW'(i_index);
                            end
                        end
                        MODE_SEARCH: begin
                            if (empty) begin
                                o_res_valid = 1'b1;
                                o_res = '{ST_NOTFOUND, i_value, '0, fc_cur, 1'b1};
                            end else begin
                                o_mem_raddr  = '0;
                                n_ptr        = '0;
                                n_nmatch     = '0;
                                n_pend_valid = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                o_res_valid = 1'b1;
                o_res = '{ST_OK, i_mem_rdata, r_idx, fc_cur, 1'b1};
            end
            S_SHIFT_UP: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = AW'(r_ptr);
                o_mem_wdata = i_mem_rdata;
                o_mem_raddr = AW'(r_ptr - 2'd2);
                n_ptr       = CW'(r_ptr - 1'b1);
            end
            S_PLACE: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = AW'(r_idx);
                o_mem_wdata = r_val;
                n_count     = CW'(r_count + 1'b1);
                o_res_valid = 1'b1;
                o_res = '{ST_OK, r_val, r_idx, fc_inc, 1'b1};
            end
            S_DEL_GRAB: begin
                n_word      = i_mem_rdata;
                o_mem_raddr = AW'(r_ptr + 1'b1);
            end
            S_SHIFT_DN: begin
                if (dn_more) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = AW'(r_ptr);
                    o_mem_wdata = i_mem_rdata;
                    o_mem_raddr = AW'(r_ptr + 2'd2);
                    n_ptr       = CW'(r_ptr + 1'b1);
                end else begin
                    n_count     = CW'(r_count - 1'b1);
                    o_res_valid = 1'b1;
                    o_res = '{ST_OK, r_word, r_idx, fc_dec, 1'b1};
                end
            end
            S_SEARCH: begin
                o_mem_raddr = AW'(r_ptr + 1'b1);
                n_ptr       = CW'(r_ptr + 1'b1);
                if (match) begin
                    // previous match goes out, this one waits to learn if it is final
                    o_res_valid  = r_pend_valid;
                    o_res = '{ST_OK, r_val, POS_W'(r_pend_pos), fc_cur, 1'b0};
                    n_pend_pos   = r_ptr;
                    n_pend_valid = 1'b1;
                    n_nmatch     = MATCH_W'(r_nmatch + 1'b1);
                end
            end
            S_FLUSH: begin
                o_res_valid = 1'b1;
                if (r_pend_valid) begin
                    o_res = '{ST_OK, r_val, POS_W'(r_pend_pos), fc_cur, 1'b1};
                end else begin
                    o_res = '{ST_NOTFOUND, r_val, '0, fc_cur, 1'b1};
                end
            end
            default: begin
            end
        endcase
    end

endmodule

>>> hw/rtl/ordered_array_list_engine_unit.sv
// Ordered list of signed 32-bit words, CAPACITY entries, with a fill count.
// Request channel: drive i_mode, i_value, i_index and raise start; the
// transaction is taken at a rising edge where start is high and busy low.
// Modes: append, pop, insert, delete, read, search; modes 6 and 7 are taken
// and dropped without a result.
// Result channel: o_strobe marks one result per cycle on o_status, o_data,
// o_position, o_fill_count, o_last; o_last flags the final result of a
// request. Results cannot be held off and leave the output register the
// cycle after they are formed.
// Steps: append, an insert at the count, a search of an empty list and any
// error form their result at accept; read and pop report the RAM word in
// S_READ; other inserts shift words up from the top (S_SHIFT_UP), then
// write the value (S_PLACE); delete grabs the word, then shifts the words
// above it down (S_SHIFT_DN). Search walks one word per cycle, holds each
// match until the next is found, and ends in S_FLUSH, sooner at the match
// limit. busy is high in every state but S_IDLE, so the next request is
// taken at the earliest at the edge that ends the final strobe. One RAM
// with one read and one write port moves a word per cycle.
// Reset (synchronous, i_rst_n low) empties the list; RAM contents are left
// as they are, and words past the fill count never reach a result.
module ordered_array_list_engine_unit
    import oale_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [MODE_W-1:0]        i_mode,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [POS_W-1:0]         i_index,
    output logic                     o_strobe,
    output logic [2:0]               o_status,
    output logic signed [DATA_W-1:0] o_data,
    output logic [POS_W-1:0]         o_position,
    output logic [FILL_W-1:0]        o_fill_count,
    output logic                     o_last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]            mem_raddr;
    logic signed [DATA_W-1:0] mem_rdata;
    logic                     res_valid;
    t_result                  res;

    logic                     r_strobe;
    t_result                  r_res;

    oale_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    oale_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_mode      (i_mode),
        .i_value     (i_value),
        .i_index     (i_index),
        .o_busy      (busy),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_res <= res;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_status     = r_res.status;
    assign o_data       = r_res.data;
    assign o_position   = r_res.position;
    assign o_fill_count = r_res.fill_count;
    assign o_last       = r_res.last;

endmodule
